// File: hdl/khts_pkg.sv
// ----------------------------------------------------------------------------
// khts_pkg
// Shared types, constants and helpers for the two-strand k-mer histogram.
// ----------------------------------------------------------------------------
package khts_pkg;

    localparam int MAX_K         = 8;
    localparam int COUNT_BITS    = 32;
    localparam int CODE_BITS     = 2 * MAX_K;
    localparam int TABLE_DEPTH   = 1 << CODE_BITS;
    localparam int K_BITS        = $clog2(MAX_K + 1);
    localparam int OUT_BITS      = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 4;

    typedef logic [CODE_BITS-1:0]     t_code;
    typedef logic [COUNT_BITS-1:0]    t_count;
    typedef logic [K_BITS-1:0]        t_klen;
    typedef logic [CFG_DATA_BITS-1:0] t_cfg_data;

    localparam logic [CFG_IDX_BITS-1:0] CFG_KMER_LENGTH       = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOTH_STRANDS      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PALINDROMES_TWICE = 2'd2;

    localparam t_cfg_data KLEN_RESET = 4'd8;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [1:0] {
        MEM_IDLE,
        MEM_READ,
        MEM_INC,
        MEM_CLEAR
    } t_mem_op;

    typedef struct packed {
        t_mem_op op;
        t_code   addr;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_RD1,
        S_WR1,
        S_RD2,
        S_WR2,
        S_DONE
    } t_state;

    function automatic t_klen eff_k(t_cfg_data len);
        t_klen k;
        if (len == '0) begin
            k = t_klen'(1);
        end else if (32'(len) > MAX_K) begin
            k = t_klen'(MAX_K);
        end else begin
            k = t_klen'(len);
        end
        return k;
    endfunction

    function automatic t_code word_mask(t_klen k);
        t_code m;
        m = '0;
        for (int i = 0; i < MAX_K; i++) begin
            m[2*i +: 2] = (32'(k) > i) ? 2'b11 : 2'b00;
        end
        return m;
    endfunction

    // code must already be masked to k bases
    function automatic t_code rev_comp(t_code code, t_klen k);
        t_code full;
        full = '0;
        for (int i = 0; i < MAX_K; i++) begin
            full[2*(MAX_K-1-i) +: 2] = ~code[2*i +: 2];
        end
        return full >> (2 * (MAX_K - 32'(k)));
    endfunction

    function automatic logic [OUT_BITS-1:0] show_count(t_count v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'hFFFF_FFFF) ? '1 : w[OUT_BITS-1:0];
    endfunction

endpackage

// File: hdl/khts_base_shift.sv
// ----------------------------------------------------------------------------
// khts_base_shift
// Rolling base code and per-sequence base count.
// ----------------------------------------------------------------------------
module khts_base_shift
    import khts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [1:0]  i_base,
    input  logic        i_seq_start,
    output t_code       o_roll,
    output t_klen       o_seen
);

    t_code r_roll, n_roll;
    t_klen r_seen, n_seen;
    t_code w_prev_roll;
    t_klen w_prev_seen;

    always_comb begin
        w_prev_roll = i_seq_start ? '0 : r_roll;
        w_prev_seen = i_seq_start ? '0 : r_seen;
        n_roll      = t_code'({w_prev_roll, i_base});
        n_seen      = (w_prev_seen == t_klen'(MAX_K)) ? w_prev_seen
                                                       : w_prev_seen + t_klen'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll <= '0;
            r_seen <= '0;
        end else if (i_push) begin
            r_roll <= n_roll;
            r_seen <= n_seen;
        end
    end

    assign o_roll = r_roll;
    assign o_seen = r_seen;

endmodule

// File: hdl/khts_count_unit.sv
// ----------------------------------------------------------------------------
// khts_count_unit
// Counter memory with one shared saturating incrementer (read, then write).
// ----------------------------------------------------------------------------
module khts_count_unit
    import khts_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_count   o_rd_data,
    output t_count   o_inc_data
);

    t_count mem [TABLE_DEPTH];
    t_count r_rd_data;
    t_count w_inc;
    t_count w_wdata;
    logic   w_we;

    always_comb begin
        w_inc   = (&r_rd_data) ? r_rd_data : r_rd_data + t_count'(1);
        w_we    = (i_req.op == MEM_INC) || (i_req.op == MEM_CLEAR);
        w_wdata = (i_req.op == MEM_CLEAR) ? '0 : w_inc;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[i_req.addr] <= w_wdata;
        end
        if (i_req.op == MEM_READ) begin
            r_rd_data <= mem[i_req.addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_inc_data = w_inc;

endmodule

// File: hdl/kmer_histogram_two_strand.sv
// ----------------------------------------------------------------------------
// kmer_histogram_two_strand
// k-mer histogram over a base stream, optionally counting both strands.
// ----------------------------------------------------------------------------
// Input stream: tuser = {seq_start, cmd}; tdata = {read_index, base}.
// cmd push shifts a base into the rolling code and, once k bases of the
// sequence are in, increments the forward k-mer counter and, in two-strand
// mode, the reverse complement counter, palindromes only with palindromes_twice. cmd
// read returns one counter. Output stream: one transfer per input transfer, tdata =
// {revcomp_code, forward_code, total_counted, count_value}, tuser = code_valid.
// Configuration: write kmer_length, both_strands, palindromes_twice through
// i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// Timing: one item at a time, through S_PREP, then S_RD1 and S_WR1 for a read or
// the forward update, S_RD2 and S_WR2 for the reverse complement update, then
// S_DONE, which loads the result; an incomplete k-mer goes straight to S_DONE.
// Each update reads then writes the single-port memory via the shared incrementer.
// Reset: the 4^MAX_K counters are zeroed by a sweep, one entry per cycle;
// s_axis_tready stays low until it ends.
// A stalled receiver holds the result register; the next item may be taken
// meanwhile, but its result waits until the register is free.
// ----------------------------------------------------------------------------
module kmer_histogram_two_strand
    import khts_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  t_cfg_data                i_cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [23:0]              s_axis_tdata,  // base[1:0], read_index[17:2], pad
    input  logic [1:0]               s_axis_tuser,  // cmd[0], seq_start[1]
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [95:0]              m_axis_tdata,  // count_value[31:0],
                                                    // total_counted[63:32],
                                                    // forward_code[79:64],
                                                    // revcomp_code[95:80]
    output logic                     m_axis_tuser   // code_valid
);

    t_state     r_state, n_state;
    t_mem_req   w_req;
    t_count     w_rd_data;
    t_count     w_inc_data;
    t_code      w_roll;
    t_klen      w_seen;
    t_klen      w_k;
    t_code      w_mask;
    t_code      w_code_src;
    logic       w_complete;
    logic       w_second;
    logic       w_accept;
    logic       w_push;
    logic       w_out_load;

    t_code      r_clr_addr;
    t_cfg_data  r_klen;
    logic       r_both;
    logic       r_pal2;
    logic [OUT_BITS-1:0] r_total;
    logic       r_out_valid;

    t_code      r_code;
    t_code      r_rc;
    t_count     r_cnt;
    logic       r_is_read;
    logic       r_code_valid;
    logic [95:0] r_out_data;
    logic       r_out_user;

    khts_base_shift u_shift (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_base      (s_axis_tdata[1:0]),
        .i_seq_start (s_axis_tuser[1]),
        .o_roll      (w_roll),
        .o_seen      (w_seen)
    );

    khts_count_unit u_count (
        .i_clk      (i_clk),
        .i_req      (w_req),
        .o_rd_data  (w_rd_data),
        .o_inc_data (w_inc_data)
    );

    always_comb begin
        w_k        = eff_k(r_klen);
        w_mask     = word_mask(w_k);
        w_code_src = r_is_read ? r_code : (w_roll & w_mask);
        w_complete = r_is_read || (w_seen >= w_k);
        w_second   = r_both && ((r_rc != r_code) || r_pal2);
        w_accept   = s_axis_tvalid && s_axis_tready;
        w_push     = w_accept && (s_axis_tuser[0] == CMD_PUSH);
        w_out_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        w_req.op      = MEM_IDLE;
        w_req.addr    = r_code;
        s_axis_tready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_req.op   = MEM_CLEAR;
                w_req.addr = r_clr_addr;
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = w_complete ? S_RD1 : S_DONE;
            end
            S_RD1: begin
                w_req.op = MEM_READ;
                n_state  = S_WR1;
            end
            S_WR1: begin
                if (r_is_read) begin
                    n_state = S_DONE;
                end else begin
                    w_req.op = MEM_INC;
                    n_state  = w_second ? S_RD2 : S_DONE;
                end
            end
            S_RD2: begin
                w_req.op   = MEM_READ;
                w_req.addr = r_rc;
                n_state    = S_WR2;
            end
            S_WR2: begin
                w_req.op   = MEM_INC;
                w_req.addr = r_rc;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_klen      <= KLEN_RESET;
            r_both      <= 1'b1;
            r_pal2      <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KMER_LENGTH:       r_klen <= i_cfg_data;
                    CFG_BOTH_STRANDS:      r_both <= i_cfg_data[0];
                    CFG_PALINDROMES_TWICE: r_pal2 <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + t_code'(1);
            end
            if (((r_state == S_WR1) && !r_is_read) || (r_state == S_WR2)) begin
                if (r_total != '1) begin
                    r_total <= r_total + 1'b1;
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_is_read <= (s_axis_tuser[0] == CMD_READ);
                    r_code    <= t_code'(s_axis_tdata[17:2]) & w_mask;
                end
            end
            S_PREP: begin
                r_code_valid <= !r_is_read && w_complete;
                r_cnt        <= '0;
                if (w_complete) begin
                    r_code <= w_code_src;
                    r_rc   <= rev_comp(w_code_src, w_k);
                end else begin
                    r_code <= '0;
                    r_rc   <= '0;
                end
            end
            S_WR1: begin
                r_cnt <= r_is_read ? w_rd_data : w_inc_data;
            end
            S_WR2: begin
                if (r_rc == r_code) begin
                    r_cnt <= w_inc_data;
                end
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_out_data <= {16'(r_rc), 16'(r_code), r_total, show_count(r_cnt)};
            r_out_user <= r_code_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_PREP))
        else $error("accepted transfer did not start processing");

    a_counted_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[63:32] != 32'd0))
        else $error("counted k-mer reported with zero total");

    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_total >= $past(r_total)))
        else $error("increment total went down");

endmodule
